// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL; clocked on i_clk, disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define ASSERT_IMPLY(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/gsf_pkg.sv -----
// Shared constants, types and GCR coding for the GCR sector formatter
package gsf_pkg;

    localparam int DATA_BYTES   = 256;
    localparam int MAX_TAIL_GAP = 20;

    localparam int CHUNK_BITS = 40;
    localparam int MAX_CHUNKS = 8;
    localparam int STEP_BITS  = CHUNK_BITS * MAX_CHUNKS;
    localparam int HEADER_GAP = 9;
    localparam int SYNC_BITS  = 40;
    localparam int GCR_BITS   = 10;

    localparam int CNT_W  = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int LEN_W  = $clog2(STEP_BITS + 1);
    localparam int CLEN_W = $clog2(CHUNK_BITS + 1);
    localparam int GAP_W  = $clog2(MAX_TAIL_GAP + 32);

    // header sync, 8 header bytes, header gap, data sync, data block ID
    localparam int HEAD_BITS  = 2 * SYNC_BITS + 9 * GCR_BITS + 8 * HEADER_GAP;
    localparam int FIRST_BITS = HEAD_BITS + GCR_BITS;
    localparam int TRAIL_BITS = 3 * GCR_BITS;

    localparam int ROOM_FIRST = (STEP_BITS - FIRST_BITS - TRAIL_BITS) / 8;
    localparam int ROOM_MID   = (STEP_BITS - GCR_BITS - TRAIL_BITS) / 8;
    localparam int GAP_LIM_FIRST = (MAX_TAIL_GAP < ROOM_FIRST) ? MAX_TAIL_GAP : ROOM_FIRST;
    localparam int GAP_LIM_MID   = (MAX_TAIL_GAP < ROOM_MID) ? MAX_TAIL_GAP : ROOM_MID;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_NO_HEADER   = 3'd1;
    localparam logic [2:0] ERR_NO_SYNC     = 3'd2;
    localparam logic [2:0] ERR_NO_DATA     = 3'd3;
    localparam logic [2:0] ERR_DATA_SUM    = 3'd4;
    localparam logic [2:0] ERR_HDR_SUM     = 3'd5;
    localparam logic [2:0] ERR_ID_MISMATCH = 3'd6;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DISK_ID_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISK_ID_TWO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_GAP    = 2'd2;

    localparam logic [4:0] TAIL_GAP_RESET = 5'd9;

    localparam logic [7:0] HDR_BLOCK_ID  = 8'h08;
    localparam logic [7:0] DATA_BLOCK_ID = 8'h07;
    localparam logic [7:0] HDR_PAD       = 8'h0F;
    localparam logic [7:0] GAP_BYTE      = 8'h55;
    localparam logic [7:0] BLANK_BYTE    = 8'h00;

    localparam logic [4:0] GCR_TABLE [16] = '{
        5'h0A, 5'h0B, 5'h12, 5'h13, 5'h0E, 5'h0F, 5'h16, 5'h17,
        5'h09, 5'h19, 5'h1A, 5'h1B, 5'h0D, 5'h1D, 5'h1E, 5'h15
    };

    typedef struct packed {
        logic [STEP_BITS-1:0] bits;
        logic [LEN_W-1:0]     len;
        logic                 ends_sector;
    } t_frame;

    function automatic logic [GCR_BITS-1:0] gcr_byte(input logic [7:0] b);
        return {GCR_TABLE[b[7:4]], GCR_TABLE[b[3:0]]};
    endfunction

endpackage

// ----- src/gcr_sector_formatter.sv -----
// Top level of the GCR sector formatter: configuration registers and datapath
// Takes one sector data byte per item and returns the sector's raw GCR track
// bits as chunks of up to 40 bits, first written bit in the highest valid
// position, with last_chunk marking the end of the sector. A middle byte gives
// one 10-bit chunk and, unless the output stalls, the block takes one such
// item every cycle. The first byte of a sector gives 252 bits (sync, header,
// gap, sync, data ID, data) and the last byte adds the checksum, two zero bytes
// and the tail gap; the frame register holds these items while they are cut
// into 7 chunks for the first byte and 1 to 5 chunks for the last, and the next
// item is taken in the cycle their final chunk moves to the output register.
// Configuration writes take effect on the next accepted item.
`include "assert_macros.svh"

module gcr_sector_formatter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_data_byte,
    input  logic [5:0]                         i_track,
    input  logic [4:0]                         i_sector,
    input  logic [2:0]                         i_error_kind,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [gsf_pkg::CHUNK_BITS-1:0]     o_chunk_data,
    output logic [gsf_pkg::CLEN_W-1:0]         o_chunk_length,
    output logic                               o_last_chunk
);

    logic [7:0] r_disk_id_one;
    logic [7:0] r_disk_id_two;
    logic [4:0] r_tail_gap;

    logic            busy;
    logic            take;
    gsf_pkg::t_frame n_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_id_one <= 8'h00;
            r_disk_id_two <= 8'h00;
            r_tail_gap    <= gsf_pkg::TAIL_GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gsf_pkg::REG_DISK_ID_ONE: r_disk_id_one <= i_cfg_data;
                gsf_pkg::REG_DISK_ID_TWO: r_disk_id_two <= i_cfg_data;
                gsf_pkg::REG_TAIL_GAP:    r_tail_gap    <= i_cfg_data[4:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign o_in_stall = busy;
    assign take       = i_in_valid && !busy;

    gsf_sector_ctl u_sector_ctl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_data_byte      (i_data_byte),
        .i_track          (i_track),
        .i_sector         (i_sector),
        .i_error_kind     (i_error_kind),
        .i_disk_id_one    (r_disk_id_one),
        .i_disk_id_two    (r_disk_id_two),
        .i_tail_gap_bytes (r_tail_gap),
        .o_frame          (n_frame)
    );

    gsf_chunker u_chunker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_frame        (n_frame),
        .o_busy         (busy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_chunk_data   (o_chunk_data),
        .o_chunk_length (o_chunk_length),
        .o_last_chunk   (o_last_chunk)
    );

    `ASSERT_IMPLY(a_chunk_len_range, o_out_valid, (o_chunk_length != '0) && (o_chunk_length <= gsf_pkg::CLEN_W'(gsf_pkg::CHUNK_BITS)), "chunk length out of range")
    `ASSERT_IMPLY(a_chunk_upper_clear, o_out_valid, (o_chunk_data >> o_chunk_length) == '0, "bits above chunk length are set")
    `ASSERT_IMPLY(a_sector_end_len, take && n_frame.ends_sector, n_frame.len >= gsf_pkg::LEN_W'(gsf_pkg::GCR_BITS + gsf_pkg::TRAIL_BITS), "sector end frame too short")

endmodule

// ----- src/gsf_sector_ctl.sv -----
// Sector state and combinational assembly of one item's raw bit frame
module gsf_sector_ctl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_data_byte,
    input  logic [5:0]            i_track,
    input  logic [4:0]            i_sector,
    input  logic [2:0]            i_error_kind,
    input  logic [7:0]            i_disk_id_one,
    input  logic [7:0]            i_disk_id_two,
    input  logic [4:0]            i_tail_gap_bytes,
    output gsf_pkg::t_frame       o_frame
);

    logic [gsf_pkg::CNT_W-1:0] r_cnt;
    logic [7:0]                r_dsum;
    logic [2:0]                r_held_err;

    logic                              first;
    logic                              last;
    logic [2:0]                        err;
    logic [gsf_pkg::SYNC_BITS-1:0]     sync;
    logic [7:0]                        hsum;
    logic [7:0]                        id1;
    logic [7:0]                        id2;
    logic [7:0]                        hdr_id;
    logic [7:0]                        data_id;
    logic [7:0]                        dsum_new;
    logic [7:0]                        dsum_out;
    logic [gsf_pkg::HEAD_BITS-1:0]     head;
    logic [gsf_pkg::TRAIL_BITS-1:0]    trail;
    logic [gsf_pkg::STEP_BITS-1:0]     gap_fill;
    logic [gsf_pkg::STEP_BITS-1:0]     bits_first;
    logic [gsf_pkg::STEP_BITS-1:0]     bits_mid;
    logic [gsf_pkg::GAP_W-1:0]         gap_lim;
    logic [gsf_pkg::GAP_W-1:0]         gap;
    logic [gsf_pkg::LEN_W-1:0]         base_len;

    always_comb begin
        first = (r_cnt == '0);
        last  = (r_cnt == gsf_pkg::CNT_W'(gsf_pkg::DATA_BYTES - 1));
        err   = first ? i_error_kind : r_held_err;

        sync  = (err == gsf_pkg::ERR_NO_SYNC) ? '0 : '1;
        hsum  = i_disk_id_one ^ i_disk_id_two ^ {2'b00, i_track} ^ {3'b000, i_sector};
        if (err == gsf_pkg::ERR_HDR_SUM) begin
            hsum = ~hsum;
        end
        id1 = (err == gsf_pkg::ERR_ID_MISMATCH) ? ~i_disk_id_one : i_disk_id_one;
        id2 = (err == gsf_pkg::ERR_ID_MISMATCH) ? ~i_disk_id_two : i_disk_id_two;
        hdr_id  = (err == gsf_pkg::ERR_NO_HEADER) ? gsf_pkg::BLANK_BYTE : gsf_pkg::HDR_BLOCK_ID;
        data_id = (err == gsf_pkg::ERR_NO_DATA) ? gsf_pkg::BLANK_BYTE : gsf_pkg::DATA_BLOCK_ID;

        dsum_new = first ? i_data_byte : (r_dsum ^ i_data_byte);
        dsum_out = (err == gsf_pkg::ERR_DATA_SUM) ? ~dsum_new : dsum_new;

        head = {sync,
                gsf_pkg::gcr_byte(hdr_id),
                gsf_pkg::gcr_byte(hsum),
                gsf_pkg::gcr_byte({3'b000, i_sector}),
                gsf_pkg::gcr_byte({2'b00, i_track}),
                gsf_pkg::gcr_byte(id2),
                gsf_pkg::gcr_byte(id1),
                gsf_pkg::gcr_byte(gsf_pkg::HDR_PAD),
                gsf_pkg::gcr_byte(gsf_pkg::HDR_PAD),
                {gsf_pkg::HEADER_GAP{gsf_pkg::GAP_BYTE}},
                sync,
                gsf_pkg::gcr_byte(data_id)};
        trail = {gsf_pkg::gcr_byte(dsum_out),
                 gsf_pkg::gcr_byte(gsf_pkg::BLANK_BYTE),
                 gsf_pkg::gcr_byte(gsf_pkg::BLANK_BYTE)};

        // tail gap starts on an even bit, so the alternating fill lines up
        gap_fill   = {(gsf_pkg::STEP_BITS / 8){gsf_pkg::GAP_BYTE}};
        bits_first = {head, gsf_pkg::gcr_byte(i_data_byte), trail,
                      gap_fill[gsf_pkg::STEP_BITS-gsf_pkg::FIRST_BITS-gsf_pkg::TRAIL_BITS-1:0]};
        bits_mid   = {gsf_pkg::gcr_byte(i_data_byte), trail,
                      gap_fill[gsf_pkg::STEP_BITS-gsf_pkg::GCR_BITS-gsf_pkg::TRAIL_BITS-1:0]};

        gap_lim  = first ? gsf_pkg::GAP_W'(gsf_pkg::GAP_LIM_FIRST)
                         : gsf_pkg::GAP_W'(gsf_pkg::GAP_LIM_MID);
        gap      = (gsf_pkg::GAP_W'(i_tail_gap_bytes) > gap_lim)
                   ? gap_lim : gsf_pkg::GAP_W'(i_tail_gap_bytes);
        base_len = first ? gsf_pkg::LEN_W'(gsf_pkg::FIRST_BITS)
                         : gsf_pkg::LEN_W'(gsf_pkg::GCR_BITS);

        o_frame.bits        = first ? bits_first : bits_mid;
        o_frame.ends_sector = last;
        o_frame.len         = last ? (base_len + gsf_pkg::LEN_W'(gsf_pkg::TRAIL_BITS)
                                      + gsf_pkg::LEN_W'({gap, 3'b000}))
                                   : base_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_dsum     <= '0;
            r_held_err <= gsf_pkg::ERR_NONE;
        end else if (i_take) begin
            r_cnt  <= last ? '0 : r_cnt + 1'b1;
            r_dsum <= last ? 8'h00 : dsum_new;
            if (first) begin
                r_held_err <= i_error_kind;
            end
        end
    end

endmodule

// ----- src/gsf_chunker.sv -----
// Frame register and output chunk register: cuts each frame into chunks of up to 40 bits
module gsf_chunker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  gsf_pkg::t_frame                   i_frame,
    output logic                              o_busy,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [gsf_pkg::CHUNK_BITS-1:0]    o_chunk_data,
    output logic [gsf_pkg::CLEN_W-1:0]        o_chunk_length,
    output logic                              o_last_chunk
);

    logic                               r_fv;
    logic [gsf_pkg::STEP_BITS-1:0]      r_frame;
    logic [gsf_pkg::LEN_W-1:0]          r_rem;
    logic                               r_fend;
    logic                               r_ov;
    logic [gsf_pkg::CHUNK_BITS-1:0]     r_odata;
    logic [gsf_pkg::CLEN_W-1:0]         r_olen;
    logic                               r_olast;

    logic                               drain;
    logic                               fin;
    logic [gsf_pkg::CLEN_W-1:0]         chunk_len;
    logic [gsf_pkg::CHUNK_BITS-1:0]     chunk;

    always_comb begin
        drain     = r_fv && (!r_ov || !i_out_stall);
        fin       = (r_rem <= gsf_pkg::LEN_W'(gsf_pkg::CHUNK_BITS));
        chunk_len = fin ? r_rem[gsf_pkg::CLEN_W-1:0] : gsf_pkg::CLEN_W'(gsf_pkg::CHUNK_BITS);
        // right-align a short final chunk, clearing the unused upper bits
        chunk     = r_frame[gsf_pkg::STEP_BITS-1 -: gsf_pkg::CHUNK_BITS]
                    >> (gsf_pkg::CLEN_W'(gsf_pkg::CHUNK_BITS) - chunk_len);
        // free the frame register when its final chunk moves out this cycle
        o_busy    = r_fv && !(drain && fin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_take) begin
                r_fv <= 1'b1;
            end else if (drain && fin) begin
                r_fv <= 1'b0;
            end
            if (drain) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_frame <= i_frame.bits;
            r_rem   <= i_frame.len;
            r_fend  <= i_frame.ends_sector;
        end else if (drain) begin
            r_frame <= r_frame << gsf_pkg::CHUNK_BITS;
            r_rem   <= r_rem - gsf_pkg::LEN_W'(chunk_len);
        end
        if (drain) begin
            r_odata <= chunk;
            r_olen  <= chunk_len;
            r_olast <= r_fend && fin;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_chunk_data   = r_odata;
    assign o_chunk_length = r_olen;
    assign o_last_chunk   = r_olast;

endmodule

// ----- dv/tb.sv -----
// Testbench for gcr_sector_formatter: directed and random items checked against a predictor
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_ITEMS   = 10;
    localparam int CALM_ITEMS     = 5;
    localparam int NUM_ROWS       = 7;

    localparam logic [gsf_pkg::CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
    localparam logic [2:0]                    ERR_UNDEFINED = 3'd7;

    localparam logic [7:0] HDR_MARK  = 8'h08;
    localparam logic [7:0] DATA_MARK = 8'h07;
    localparam logic [7:0] HDR_FILL  = 8'h0F;
    localparam logic [7:0] GAP_FILL  = 8'h55;
    localparam logic [7:0] ZERO_FILL = 8'h00;

    localparam logic [gsf_pkg::CHUNK_BITS-1:0] ALL_ONES = {gsf_pkg::CHUNK_BITS{1'b1}};

    localparam logic [4:0] NIBBLE_CODE [16] = '{
        5'h0A, 5'h0B, 5'h12, 5'h13, 5'h0E, 5'h0F, 5'h16, 5'h17,
        5'h09, 5'h19, 5'h1A, 5'h1B, 5'h0D, 5'h1D, 5'h1E, 5'h15
    };

    localparam logic [gsf_pkg::CFG_IDX_W-1:0] REG_ORDER [4] = '{
        gsf_pkg::REG_DISK_ID_ONE, gsf_pkg::REG_DISK_ID_TWO, gsf_pkg::REG_TAIL_GAP, REG_SPARE
    };

    typedef enum logic [1:0] {AT_FIRST, AT_MID, AT_LAST} t_slot;

    typedef struct packed {
        t_slot                              slot;
        logic                               reconfig;
        logic [7:0]                         id_one;
        logic [7:0]                         id_two;
        logic [7:0]                         gap_cfg;
        logic [7:0]                         data;
        logic [5:0]                         track;
        logic [4:0]                         sector;
        logic [2:0]                         kind;
        logic                               typed;
        logic [gsf_pkg::CHUNK_BITS-1:0]     exp_data;
        logic [gsf_pkg::CLEN_W-1:0]         exp_len;
    } t_plan_row;

    typedef struct packed {
        logic [gsf_pkg::CHUNK_BITS-1:0]     data;
        logic [gsf_pkg::CLEN_W-1:0]         len;
        logic                               last;
    } t_chunk;

    // typed expectations cover only the first chunk of the row's item
    localparam t_plan_row PLAN [NUM_ROWS] = '{
        '{AT_FIRST, 1'b1, 8'hA5, 8'h5A, 8'hFF,
          8'hC3, 6'd42, 5'd20, gsf_pkg::ERR_DATA_SUM, 1'b1, ALL_ONES, 6'd40},
        '{AT_MID,   1'b0, 8'h00, 8'h00, 8'h00,
          8'h00, 6'd0,  5'd0,  gsf_pkg::ERR_NONE,     1'b1, 40'h14A,  6'd10},
        '{AT_MID,   1'b0, 8'h00, 8'h00, 8'h00,
          8'hFF, 6'd63, 5'd31, ERR_UNDEFINED,         1'b1, 40'h2B5,  6'd10},
        '{AT_MID,   1'b0, 8'h00, 8'h00, 8'h00,
          8'h55, 6'd0,  5'd0,  gsf_pkg::ERR_NONE,     1'b1, 40'h1EF,  6'd10},
        '{AT_MID,   1'b0, 8'h00, 8'h00, 8'h00,
          8'h81, 6'd0,  5'd0,  gsf_pkg::ERR_NONE,     1'b0, 40'h0,    6'd0},
        '{AT_LAST,  1'b0, 8'h00, 8'h00, 8'h00,
          8'h7E, 6'd0,  5'd0,  gsf_pkg::ERR_NONE,     1'b0, 40'h0,    6'd0},
        '{AT_FIRST, 1'b0, 8'h00, 8'h00, 8'h00,
          8'h00, 6'd63, 5'd31, gsf_pkg::ERR_NO_SYNC,  1'b1, 40'h0,    6'd40}
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [gsf_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [7:0]                         i_cfg_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic [7:0]                         i_data_byte = '0;
    logic [5:0]                         i_track = '0;
    logic [4:0]                         i_sector = '0;
    logic [2:0]                         i_error_kind = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [gsf_pkg::CHUNK_BITS-1:0]     o_chunk_data;
    logic [gsf_pkg::CLEN_W-1:0]         o_chunk_length;
    logic                               o_last_chunk;

    // sideband that travels with the item: typed first-chunk expectation
    logic                               row_typed = 1'b0;
    logic [gsf_pkg::CHUNK_BITS-1:0]     row_exp_data = '0;
    logic [gsf_pkg::CLEN_W-1:0]         row_exp_len = '0;

    // predictor copy of the registers and sector state
    logic [7:0]                         id_one = '0;
    logic [7:0]                         id_two = '0;
    logic [4:0]                         tail_gap = gsf_pkg::TAIL_GAP_RESET;
    int unsigned                        sector_pos = 0;
    logic [7:0]                         data_xor = '0;
    logic [5:0]                         held_track = '0;
    logic [4:0]                         held_sector = '0;
    logic [2:0]                         held_err = '0;

    logic [gsf_pkg::STEP_BITS-1:0]      step_bits;
    int                                 step_len;

    t_chunk                             expected_chunks [$];
    int                                 mismatches = 0;
    int                                 stuck_cycles = 0;
    int                                 idle_odds = 5;
    int                                 stall_left = 0;
    int unsigned                        bytes_in_sector = 0;

    gcr_sector_formatter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_track        (i_track),
        .i_sector       (i_sector),
        .i_error_kind   (i_error_kind),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_chunk_data   (o_chunk_data),
        .o_chunk_length (o_chunk_length),
        .o_last_chunk   (o_last_chunk)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void put_bits(input logic [gsf_pkg::CHUNK_BITS-1:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            // drop anything past one step's worth of chunks
            if (step_len < gsf_pkg::STEP_BITS) begin
                step_bits = {step_bits[gsf_pkg::STEP_BITS-2:0], v[i]};
                step_len++;
            end
        end
    endfunction

    function automatic void put_gcr(input logic [7:0] b);
        put_bits({30'd0, NIBBLE_CODE[b[7:4]], NIBBLE_CODE[b[3:0]]}, 10);
    endfunction

    function automatic void format_byte(input logic [7:0] d, input logic [5:0] trk,
                                        input logic [4:0] sec, input logic [2:0] kind);
        logic [7:0]                         hsum;
        logic [7:0]                         id1;
        logic [7:0]                         id2;
        logic [7:0]                         dsum;
        logic [gsf_pkg::CHUNK_BITS-1:0]     sync;
        logic [gsf_pkg::STEP_BITS-1:0]      window;
        logic [gsf_pkg::CHUNK_BITS:0]       mask;
        int                                 gap;
        int                                 room;
        int                                 take;
        logic                               ends;
        t_chunk                             c;
        step_bits = '0;
        step_len = 0;
        if (sector_pos == 0) begin
            held_track = trk;
            held_sector = sec;
            held_err = kind;
            data_xor = '0;
            hsum = id_one ^ id_two ^ {2'b00, trk} ^ {3'b000, sec};
            id1 = id_one;
            id2 = id_two;
            if (held_err == gsf_pkg::ERR_HDR_SUM)
                hsum = ~hsum;
            if (held_err == gsf_pkg::ERR_ID_MISMATCH) begin
                id1 = ~id1;
                id2 = ~id2;
            end
            sync = (held_err == gsf_pkg::ERR_NO_SYNC) ? '0 : ALL_ONES;
            put_bits(sync, gsf_pkg::CHUNK_BITS);
            put_gcr(held_err == gsf_pkg::ERR_NO_HEADER ? ZERO_FILL : HDR_MARK);
            put_gcr(hsum);
            put_gcr({3'b000, held_sector});
            put_gcr({2'b00, held_track});
            put_gcr(id2);
            put_gcr(id1);
            put_gcr(HDR_FILL);
            put_gcr(HDR_FILL);
            for (int i = 0; i < gsf_pkg::HEADER_GAP; i++)
                put_bits({32'd0, GAP_FILL}, 8);
            put_bits(sync, gsf_pkg::CHUNK_BITS);
            put_gcr(held_err == gsf_pkg::ERR_NO_DATA ? ZERO_FILL : DATA_MARK);
        end
        data_xor = data_xor ^ d;
        put_gcr(d);
        ends = (sector_pos + 1 >= gsf_pkg::DATA_BYTES);
        if (ends) begin
            dsum = (held_err == gsf_pkg::ERR_DATA_SUM) ? ~data_xor : data_xor;
            put_gcr(dsum);
            put_gcr(ZERO_FILL);
            put_gcr(ZERO_FILL);
            gap = int'(tail_gap);
            if (gap > gsf_pkg::MAX_TAIL_GAP)
                gap = gsf_pkg::MAX_TAIL_GAP;
            room = (gsf_pkg::STEP_BITS - step_len) / 8;
            if (gap > room)
                gap = room;
            for (int i = 0; i < gap; i++)
                put_bits({32'd0, GAP_FILL}, 8);
        end
        // cut from the front: full chunks, then the remainder
        for (int k = 0; k * gsf_pkg::CHUNK_BITS < step_len; k++) begin
            take = step_len - k * gsf_pkg::CHUNK_BITS;
            if (take > gsf_pkg::CHUNK_BITS)
                take = gsf_pkg::CHUNK_BITS;
            window = step_bits >> (step_len - k * gsf_pkg::CHUNK_BITS - take);
            mask = (41'd1 << take) - 41'd1;
            c.data = window[gsf_pkg::CHUNK_BITS-1:0] & mask[gsf_pkg::CHUNK_BITS-1:0];
            c.len = gsf_pkg::CLEN_W'(take);
            c.last = ends && ((k + 1) * gsf_pkg::CHUNK_BITS >= step_len);
            expected_chunks.insert(expected_chunks.size(), c);
        end
        if (ends) begin
            sector_pos = 0;
            data_xor = '0;
        end else begin
            sector_pos = sector_pos + 1;
        end
    endfunction

    function automatic void check_chunk();
        t_chunk want;
        if (expected_chunks.size() == 0) begin
            $display("%0t: unexpected chunk data=%h len=%0d last=%0b", $time,
                     o_chunk_data, o_chunk_length, o_last_chunk);
            mismatches++;
        end else begin
            want = expected_chunks.pop_front();
            if (o_chunk_data !== want.data) begin
                $display("%0t: chunk_data expected %h got %h", $time, want.data, o_chunk_data);
                mismatches++;
            end
            if (o_chunk_length !== want.len) begin
                $display("%0t: chunk_length expected %0d got %0d", $time, want.len,
                         o_chunk_length);
                mismatches++;
            end
            if (o_last_chunk !== want.last) begin
                $display("%0t: last_chunk expected %0b got %0b", $time, want.last,
                         o_last_chunk);
                mismatches++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        int     base;
        t_chunk c;
        logic   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            // check before predicting so a fresh expectation is never popped early
            if (o_out_valid && !i_out_stall) begin
                check_chunk();
                moved = 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gsf_pkg::REG_DISK_ID_ONE: id_one = i_cfg_data;
                    gsf_pkg::REG_DISK_ID_TWO: id_two = i_cfg_data;
                    gsf_pkg::REG_TAIL_GAP:    tail_gap = i_cfg_data[4:0];
                    default: ;
                endcase
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                base = expected_chunks.size();
                format_byte(i_data_byte, i_track, i_sector, i_error_kind);
                if (row_typed && expected_chunks.size() > base) begin
                    c = expected_chunks[base];
                    c.data = row_exp_data;
                    c.len = row_exp_len;
                    expected_chunks[base] = c;
                end
                moved = 1'b1;
            end
        end
        stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end

    // output back-pressure in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left <= int'($urandom_range(0, 18));
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] d, input logic [5:0] trk,
                             input logic [4:0] sec, input logic [2:0] kind,
                             input logic typed,
                             input logic [gsf_pkg::CHUNK_BITS-1:0] want_data,
                             input logic [gsf_pkg::CLEN_W-1:0] want_len);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= d;
        i_track <= trk;
        i_sector <= sec;
        i_error_kind <= kind;
        row_typed <= typed;
        row_exp_data <= want_data;
        row_exp_len <= want_len;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        bytes_in_sector = (bytes_in_sector + 1 == gsf_pkg::DATA_BYTES) ? 0
                                                                       : bytes_in_sector + 1;
    endtask

    task automatic send_random_byte();
        send_byte(8'($urandom), 6'($urandom), 5'($urandom), 3'($urandom), 1'b0, '0, '0);
    endtask

    // pad with random data bytes until the sector reaches the wanted slot
    task automatic fill_to(input t_slot slot);
        case (slot)
            AT_FIRST:
                while (bytes_in_sector != 0)
                    send_random_byte();
            AT_LAST:
                while (bytes_in_sector != gsf_pkg::DATA_BYTES - 1)
                    send_random_byte();
            default:
                while (bytes_in_sector == 0 || bytes_in_sector == gsf_pkg::DATA_BYTES - 1)
                    send_random_byte();
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chunks.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] id1, input logic [7:0] id2,
                                input logic [7:0] gap, input logic [7:0] spare);
        logic [7:0] vals [4];
        vals = '{id1, id2, gap, spare};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= REG_ORDER[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_plan_row r;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < NUM_ROWS; n++) begin
            r = PLAN[n];
            fill_to(r.slot);
            if (r.reconfig) begin
                drain();
                write_config(r.id_one, r.id_two, r.gap_cfg, ~r.gap_cfg);
            end
            send_byte(r.data, r.track, r.sector, r.kind, r.typed, r.exp_data, r.exp_len);
        end

        idle_odds = int'($urandom_range(2, 12));
        for (int b = 0; b < RANDOM_ITEMS; b++) begin
            // no idling at all in the final stretch
            if (b == RANDOM_ITEMS - CALM_ITEMS)
                idle_odds = 0;
            send_random_byte();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
